// ===== src/avz_pkg.sv =====
// ---------------------------------------------------------------------------
// avz_pkg: shared types for the align-vector-to-z rotation core
// Widths of the arithmetic words and the sideband records that travel
// beside the square-root and divider pipelines.
// ---------------------------------------------------------------------------
package avz_pkg;

  // Width of radicands, numerators and products.
  localparam int WIDE_W = 64;
  // Width of magnitudes and matrix elements.
  localparam int MAG_W  = 32;
  // Width of a square root of a wide word.
  localparam int ROOT_W = WIDE_W / 2;

  typedef logic [WIDE_W-1:0] wide_t;
  typedef logic [MAG_W-1:0]  mag_t;

  // Normalized magnitudes of the input vector on their way to the length.
  typedef struct packed {
    logic [2:0]      neg;
    logic            zero;
    logic [2:0][MAG_W-1:0] mag;
  } vec_side_t;

  // Signs and the zero flag beside the first divider.
  typedef struct packed {
    logic [2:0] neg;
    logic       zero;
  } flag_side_t;

  // Unit vector and its products beside the second square root.
  typedef struct packed {
    logic [2:0]      neg;
    logic            zero;
    logic [2:0][MAG_W-1:0] mag;
    wide_t           ab;
    wide_t           ac;
  } prod_side_t;

  // Unit vector, d and the flags beside the second divider.
  typedef struct packed {
    logic [2:0]      neg;
    logic            zero;
    logic            onx;
    logic [2:0][MAG_W-1:0] mag;
    mag_t            d;
  } quot_side_t;

endpackage

// ===== src/avz_sqrt_pipe.sv =====
// ---------------------------------------------------------------------------
// avz_sqrt_pipe: pipelined integer square root
// Floor square root of a 64-bit word, one result bit per register stage,
// with a sideband that travels beside the radicand.
// ---------------------------------------------------------------------------
module avz_sqrt_pipe #(
  parameter int SW = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [avz_pkg::WIDE_W-1:0]    rad_i,
  input  logic [SW-1:0]                 side_i,
  output logic                          valid_o,
  output logic [avz_pkg::ROOT_W-1:0]    root_o,
  output logic [SW-1:0]                 side_o
);

  localparam int STAGES = avz_pkg::ROOT_W;

  logic                valid_q [STAGES];
  avz_pkg::wide_t      rem_q   [STAGES];
  avz_pkg::wide_t      res_q   [STAGES];
  logic [SW-1:0]       side_q  [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    localparam int SH = avz_pkg::WIDE_W - 2 - 2 * s;
    logic           v_in;
    avz_pkg::wide_t rem_in, res_in, rem_d, res_d, step, trial;
    logic [SW-1:0]  side_in;

    if (s == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = rad_i;
      assign res_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = valid_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign res_in  = res_q[s-1];
      assign side_in = side_q[s-1];
    end

    // One step of the digit-by-digit root.
    always_comb begin
      step  = avz_pkg::wide_t'(1) << SH;
      trial = res_in + step;
      if (rem_in >= trial) begin
        rem_d = rem_in - trial;
        res_d = (res_in >> 1) + step;
      end else begin
        rem_d = rem_in;
        res_d = res_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en_i) begin
        valid_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_d;
        res_q[s]  <= res_d;
        side_q[s] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[STAGES-1];
  assign root_o  = res_q[STAGES-1][avz_pkg::ROOT_W-1:0];
  assign side_o  = side_q[STAGES-1];

endmodule

// ===== src/avz_div_pipe.sv =====
// ---------------------------------------------------------------------------
// avz_div_pipe: pipelined restoring divider
// Several numerators over one shared denominator, one quotient bit per
// register stage, with a sideband that travels beside the operands.
// ---------------------------------------------------------------------------
module avz_div_pipe #(
  parameter int LANES = 3,
  parameter int QB    = 32,
  parameter int SW    = 8
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   en_i,
  input  logic                                   valid_i,
  input  logic [LANES-1:0][avz_pkg::WIDE_W-1:0]  num_i,
  input  logic [avz_pkg::WIDE_W-1:0]             den_i,
  input  logic [SW-1:0]                          side_i,
  output logic                                   valid_o,
  output logic [LANES-1:0][QB-1:0]               quo_o,
  output logic [SW-1:0]                          side_o
);

  localparam int XW = avz_pkg::WIDE_W + QB;

  logic                                  valid_q [QB];
  logic [LANES-1:0][avz_pkg::WIDE_W-1:0] rem_q   [QB];
  logic [LANES-1:0][QB-1:0]              quo_q   [QB];
  avz_pkg::wide_t                        den_q   [QB];
  logic [SW-1:0]                         side_q  [QB];

  for (genvar s = 0; s < QB; s++) begin : g_stage
    localparam int SH = QB - 1 - s;
    logic                                  v_in;
    logic [LANES-1:0][avz_pkg::WIDE_W-1:0] rem_in, rem_d;
    logic [LANES-1:0][QB-1:0]              quo_in, quo_d;
    avz_pkg::wide_t                        den_in;
    logic [SW-1:0]                         side_in;
    logic [XW-1:0]                         den_sh;

    if (s == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = num_i;
      assign quo_in  = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = valid_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign quo_in  = quo_q[s-1];
      assign den_in  = den_q[s-1];
      assign side_in = side_q[s-1];
    end

    // Trial subtraction of the shifted denominator in every lane.
    always_comb begin
      den_sh = XW'(den_in) << SH;
      rem_d  = rem_in;
      quo_d  = quo_in;
      for (int l = 0; l < LANES; l++) begin
        if (XW'(rem_in[l]) >= den_sh) begin
          rem_d[l]     = rem_in[l] - den_sh[avz_pkg::WIDE_W-1:0];
          quo_d[l][SH] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en_i) begin
        valid_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_d;
        quo_q[s]  <= quo_d;
        den_q[s]  <= den_in;
        side_q[s] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[QB-1];
  assign quo_o   = quo_q[QB-1];
  assign side_o  = side_q[QB-1];

endmodule

// ===== src/align_vector_to_z_rotation_core.sv =====
// ---------------------------------------------------------------------------
// align_vector_to_z_rotation_core: rotation that aligns a vector with z
// Normalizes a Q16.16 direction vector and puts out the 3x3 rotation
// matrix in fixed point, with flags for a zero vector and the x axis.
//
//   Channel | Direction | Handshake               | Payload
//   in      | input     | in_valid_i / in_stall_o | dir_x_i, dir_y_i, dir_z_i
//   out     | output    | out_valid_o/out_stall_i | m00_o..m22_o, flags
//
// One transaction enters per cycle unless a stalled result holds the pipeline;
// the path runs through the two 32-stage square roots and the two dividers
// of ELEM_FRAC_BITS + 2 stages each. Reset clears only the valid bits.
// A stalled result freezes the whole pipeline and in_stall_o follows.
// ---------------------------------------------------------------------------
module align_vector_to_z_rotation_core #(
  parameter int ELEM_FRAC_BITS = 30
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] dir_x_i,
  input  logic [31:0] dir_y_i,
  input  logic [31:0] dir_z_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] m00_o,
  output logic [31:0] m01_o,
  output logic [31:0] m02_o,
  output logic [31:0] m10_o,
  output logic [31:0] m11_o,
  output logic [31:0] m12_o,
  output logic [31:0] m20_o,
  output logic [31:0] m21_o,
  output logic [31:0] m22_o,
  output logic        on_x_axis_o,
  output logic        zero_vector_o
);

  localparam int F  = ELEM_FRAC_BITS;
  localparam int QB = F + 2;
  localparam logic [QB-1:0] ONE_Q = QB'(1) << F;
  localparam avz_pkg::mag_t ONE   = avz_pkg::mag_t'(1) << F;

  // The pipeline advances unless a finished result is held back.
  logic adv;
  logic out_valid_q;
  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  // Stage 1: magnitudes and signs.
  logic                   v1_q;
  logic [2:0]             neg1_q;
  logic [2:0][31:0]       mag1_q;
  logic [2:0][31:0]       dir;
  assign dir = {dir_z_i, dir_y_i, dir_x_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        neg1_q[l] <= dir[l][31];
        mag1_q[l] <= dir[l][31] ? (32'd0 - dir[l]) : dir[l];
      end
    end
  end

  // Stage 2: largest magnitude and the normalizing shift.
  logic             v2_q, zero2_q;
  logic [2:0]       neg2_q;
  logic [2:0][31:0] mag2_q;
  logic [4:0]       k2_q;
  logic [31:0]      mmax;
  logic [4:0]       pos, k2_d;

  always_comb begin
    mmax = mag1_q[0];
    if (mag1_q[1] > mmax) mmax = mag1_q[1];
    if (mag1_q[2] > mmax) mmax = mag1_q[2];
    pos = '0;
    for (int i = 0; i < 30; i++) begin
      if (mmax[i]) pos = 5'(i);
    end
    k2_d = (mmax[31] || mmax[30]) ? 5'd0 : (5'd30 - pos);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      zero2_q <= (mmax == 32'd0);
      neg2_q  <= neg1_q;
      mag2_q  <= mag1_q;
      k2_q    <= k2_d;
    end
  end

  // Stage 3: shift all magnitudes by the common amount.
  logic             v3_q, zero3_q;
  logic [2:0]       neg3_q;
  logic [2:0][31:0] mag3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      zero3_q <= zero2_q;
      neg3_q  <= neg2_q;
      for (int l = 0; l < 3; l++) begin
        mag3_q[l] <= mag2_q[l] << k2_q;
      end
    end
  end

  // Stage 4: squares of the shifted magnitudes.
  logic                 v4_q;
  avz_pkg::vec_side_t   side4_q;
  avz_pkg::wide_t [2:0] sq4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (adv) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side4_q.neg  <= neg3_q;
      side4_q.zero <= zero3_q;
      side4_q.mag  <= mag3_q;
      for (int l = 0; l < 3; l++) begin
        sq4_q[l] <= avz_pkg::wide_t'(mag3_q[l]) * avz_pkg::wide_t'(mag3_q[l]);
      end
    end
  end

  // Stage 5: sum of squares into the length square root.
  logic               v5_q;
  avz_pkg::vec_side_t side5_q;
  avz_pkg::wide_t     sum5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (adv) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side5_q <= side4_q;
      sum5_q  <= sq4_q[0] + sq4_q[1] + sq4_q[2];
    end
  end

  logic                             len_valid;
  logic [avz_pkg::ROOT_W-1:0]       len;
  avz_pkg::vec_side_t               len_side;

  avz_sqrt_pipe #(
    .SW ($bits(avz_pkg::vec_side_t))
  ) u_len_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v5_q),
    .rad_i   (sum5_q),
    .side_i  (side5_q),
    .valid_o (len_valid),
    .root_o  (len),
    .side_o  (len_side)
  );

  // Stage 6: rounded numerators of the unit vector.
  logic                   v6_q;
  avz_pkg::flag_side_t    side6_q;
  avz_pkg::wide_t [2:0]   num6_q;
  avz_pkg::wide_t         den6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else if (adv) begin
      v6_q <= len_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side6_q.neg  <= len_side.neg;
      side6_q.zero <= len_side.zero;
      den6_q       <= avz_pkg::wide_t'(len);
      for (int l = 0; l < 3; l++) begin
        num6_q[l] <= (avz_pkg::wide_t'(len_side.mag[l]) << F)
                     + avz_pkg::wide_t'(len >> 1);
      end
    end
  end

  logic                    unit_valid;
  logic [2:0][QB-1:0]      unit_quo;
  avz_pkg::flag_side_t     unit_side;

  avz_div_pipe #(
    .LANES (3),
    .QB    (QB),
    .SW    ($bits(avz_pkg::flag_side_t))
  ) u_unit_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v6_q),
    .num_i   (num6_q),
    .den_i   (den6_q),
    .side_i  (side6_q),
    .valid_o (unit_valid),
    .quo_o   (unit_quo),
    .side_o  (unit_side)
  );

  // Stage 7: clamp to 1.0 and settle the signs of a, b and c.
  logic             v7_q, zero7_q;
  logic [2:0]       neg7_q;
  logic [2:0][31:0] mag7_q;
  logic [2:0][31:0] mag7_d;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      mag7_d[l] = (unit_quo[l] > ONE_Q) ? ONE : avz_pkg::mag_t'(unit_quo[l]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
    end else if (adv) begin
      v7_q <= unit_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      zero7_q <= unit_side.zero;
      mag7_q  <= mag7_d;
      for (int l = 0; l < 3; l++) begin
        neg7_q[l] <= unit_side.neg[l] && (mag7_d[l] != 32'd0);
      end
    end
  end

  // Stage 8: products for d squared and the first column.
  logic               v8_q;
  avz_pkg::prod_side_t side8_q;
  avz_pkg::wide_t     bb8_q, cc8_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v8_q <= 1'b0;
    end else if (adv) begin
      v8_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side8_q.neg  <= neg7_q;
      side8_q.zero <= zero7_q;
      side8_q.mag  <= mag7_q;
      side8_q.ab   <= avz_pkg::wide_t'(mag7_q[0]) * avz_pkg::wide_t'(mag7_q[1]);
      side8_q.ac   <= avz_pkg::wide_t'(mag7_q[0]) * avz_pkg::wide_t'(mag7_q[2]);
      bb8_q        <= avz_pkg::wide_t'(mag7_q[1]) * avz_pkg::wide_t'(mag7_q[1]);
      cc8_q        <= avz_pkg::wide_t'(mag7_q[2]) * avz_pkg::wide_t'(mag7_q[2]);
    end
  end

  // Stage 9: d squared into the second square root.
  logic                v9_q;
  avz_pkg::prod_side_t side9_q;
  avz_pkg::wide_t      d2_9_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v9_q <= 1'b0;
    end else if (adv) begin
      v9_q <= v8_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side9_q <= side8_q;
      d2_9_q  <= bb8_q + cc8_q;
    end
  end

  logic                       d_valid;
  logic [avz_pkg::ROOT_W-1:0] d_root;
  avz_pkg::prod_side_t        d_side;

  avz_sqrt_pipe #(
    .SW ($bits(avz_pkg::prod_side_t))
  ) u_d_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v9_q),
    .rad_i   (d2_9_q),
    .side_i  (side9_q),
    .valid_o (d_valid),
    .root_o  (d_root),
    .side_o  (d_side)
  );

  // Stage 10: rounded numerators over d, lanes m10, m11, m20, m21.
  logic                 v10_q;
  avz_pkg::quot_side_t  side10_q;
  avz_pkg::wide_t [3:0] num10_q;
  avz_pkg::wide_t       den10_q;
  avz_pkg::wide_t       half_d;
  assign half_d = avz_pkg::wide_t'(d_root >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v10_q <= 1'b0;
    end else if (adv) begin
      v10_q <= d_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side10_q.neg  <= d_side.neg;
      side10_q.zero <= d_side.zero;
      side10_q.onx  <= (d_root == '0);
      side10_q.mag  <= d_side.mag;
      side10_q.d    <= avz_pkg::mag_t'(d_root);
      den10_q       <= avz_pkg::wide_t'(d_root);
      num10_q[0]    <= d_side.ab + half_d;
      num10_q[1]    <= (avz_pkg::wide_t'(d_side.mag[2]) << F) + half_d;
      num10_q[2]    <= d_side.ac + half_d;
      num10_q[3]    <= (avz_pkg::wide_t'(d_side.mag[1]) << F) + half_d;
    end
  end

  logic                 col_valid;
  logic [3:0][QB-1:0]   col_quo;
  avz_pkg::quot_side_t  col_side;

  avz_div_pipe #(
    .LANES (4),
    .QB    (QB),
    .SW    ($bits(avz_pkg::quot_side_t))
  ) u_col_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v10_q),
    .num_i   (num10_q),
    .den_i   (den10_q),
    .side_i  (side10_q),
    .valid_o (col_valid),
    .quo_o   (col_quo),
    .side_o  (col_side)
  );

  // Stage 11: clamp, signs, special cases and the output register.
  logic [8:0][31:0] m_d, m_q;
  logic             onx_d, zv_d, onx_q, zv_q;
  logic [3:0][31:0] cq;
  logic [3:0]       cneg;
  logic [2:0][31:0] abc;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      cq[l] = (col_quo[l] > ONE_Q) ? ONE : avz_pkg::mag_t'(col_quo[l]);
    end
    cneg[0] = (col_side.neg[0] == col_side.neg[1]) && (col_side.mag[0] != '0)
              && (col_side.mag[1] != '0);
    cneg[1] = col_side.neg[2];
    cneg[2] = (col_side.neg[0] == col_side.neg[2]) && (col_side.mag[0] != '0)
              && (col_side.mag[2] != '0);
    cneg[3] = !col_side.neg[1] && (col_side.mag[1] != '0);
    for (int l = 0; l < 3; l++) begin
      abc[l] = col_side.neg[l] ? (32'd0 - col_side.mag[l]) : col_side.mag[l];
    end
    m_d   = '0;
    onx_d = 1'b0;
    zv_d  = 1'b0;
    if (col_side.zero) begin
      zv_d = 1'b1;
    end else if (col_side.onx) begin
      onx_d  = 1'b1;
      m_d[1] = ONE;
      m_d[5] = ONE;
      m_d[6] = ONE;
    end else begin
      m_d[0] = col_side.d;
      m_d[2] = abc[0];
      m_d[3] = cneg[0] ? (32'd0 - cq[0]) : cq[0];
      m_d[4] = cneg[1] ? (32'd0 - cq[1]) : cq[1];
      m_d[5] = abc[1];
      m_d[6] = cneg[2] ? (32'd0 - cq[2]) : cq[2];
      m_d[7] = cneg[3] ? (32'd0 - cq[3]) : cq[3];
      m_d[8] = abc[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= col_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_q   <= m_d;
      onx_q <= onx_d;
      zv_q  <= zv_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign m00_o         = m_q[0];
  assign m01_o         = m_q[1];
  assign m02_o         = m_q[2];
  assign m10_o         = m_q[3];
  assign m11_o         = m_q[4];
  assign m12_o         = m_q[5];
  assign m20_o         = m_q[6];
  assign m21_o         = m_q[7];
  assign m22_o         = m_q[8];
  assign on_x_axis_o   = onx_q;
  assign zero_vector_o = zv_q;

endmodule

// ===== src/avz_checker.sv =====
// ---------------------------------------------------------------------------
// avz_checker: port-level checks for the rotation core
// Watches the handshakes and the special-case results on the top level.
// ---------------------------------------------------------------------------
module avz_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] m00_o,
  input logic [31:0] m02_o,
  input logic [31:0] m11_o,
  input logic [31:0] m22_o,
  input logic        on_x_axis_o,
  input logic        zero_vector_o
);

  // A held result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result transaction dropped while stalled");

  // The input side stalls exactly when a result is held back.
  a_stall_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall does not follow output backpressure");

  // The two special cases exclude each other.
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(on_x_axis_o && zero_vector_o))
    else $error("both special-case flags set");

  // A zero vector gives an empty matrix and the x axis a permutation.
  a_special: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (zero_vector_o || on_x_axis_o) |->
      m00_o == 32'd0 && m02_o == 32'd0 && m11_o == 32'd0 && m22_o == 32'd0)
    else $error("special-case matrix has a nonzero element");

endmodule

bind align_vector_to_z_rotation_core avz_checker u_avz_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .m00_o         (m00_o),
  .m02_o         (m02_o),
  .m11_o         (m11_o),
  .m22_o         (m22_o),
  .on_x_axis_o   (on_x_axis_o),
  .zero_vector_o (zero_vector_o)
);
